// ===== src/fspb_pkg.sv =====
// Shared types and constants for the first-seen palette builder.
`timescale 1ns / 1ps
`default_nettype none

package fspb_pkg;

  localparam int unsigned PaletteDepthDef = 224;
  localparam logic [7:0]  CodeBase        = 8'd32;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fspb_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the incoming pixel, rewind the search
    logic scan_en;  // search runs this cycle
    logic commit;   // resolve hit/append/drop into the output register
  } fspb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // compared entry matches the pixel color
    logic scan_end;  // all stored entries compared without a match
  } fspb_sts_t;

endpackage

`default_nettype wire

// ===== src/fspb_if.sv =====
// Valid/ready stream interfaces for pixels in and codes out.
`timescale 1ns / 1ps
`default_nettype none

interface fspb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       start_req;

  modport source (output valid, red, green, blue, start_req, input ready);
  modport sink   (input valid, red, green, blue, start_req, output ready);
endinterface

interface fspb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] code;
  logic       added;
  logic       dropped;
  logic [7:0] palette_count;

  modport source (output valid, code, added, dropped, palette_count, input ready);
  modport sink   (input valid, code, added, dropped, palette_count, output ready);
endinterface

`default_nettype wire

// ===== src/fspb_ctrl.sv =====
// Controller: accepts a pixel, runs the search, hands off to the output register.
`timescale 1ns / 1ps
`default_nettype none

module fspb_ctrl
  import fspb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire fspb_sts_t sts_i,
  output fspb_cmd_t      cmd_o
);

  fspb_state_e state_q, state_d;
  logic        out_full_q, out_full_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        // result register must be free or draining this cycle
        cmd_o.commit  = (sts_i.hit || sts_i.scan_end) && (!out_full_q || out_ready_i);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_full_d = out_full_q;
    if (cmd_o.commit)     out_full_d = 1'b1;
    else if (out_ready_i) out_full_d = 1'b0;
  end

  assign out_valid_o = out_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/fspb_datapath.sv =====
// Datapath: palette memory, sequential search, entry count and result register.
`timescale 1ns / 1ps
`default_nettype none

module fspb_datapath
  import fspb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       start_req_i,
  input  wire fspb_cmd_t  cmd_i,
  output fspb_sts_t       sts_o,
  output logic [7:0]      code_o,
  output logic            added_o,
  output logic            dropped_o,
  output logic [7:0]      palette_count_o
);

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(PALETTE_DEPTH);

  logic [23:0] mem [PALETTE_DEPTH];

  logic [23:0]     color_q;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      last_q, last_d;
  logic [CntW-1:0] scan_idx_q, scan_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;
  logic [23:0]     rdata_q;
  logic            issue;
  logic            append;
  logic [7:0]      code_d;
  logic            added_d, dropped_d;

  assign sts_o.hit      = cmp_vld_q && (rdata_q == color_q);
  assign sts_o.scan_end = !cmp_vld_q && (scan_idx_q == count_q);

  // one palette read per cycle while entries remain; freeze once matched
  assign issue  = cmd_i.scan_en && !sts_o.hit && (scan_idx_q < count_q);
  assign append = cmd_i.commit && !sts_o.hit && (count_q != CntFull);

  always_comb begin
    scan_idx_d = scan_idx_q;
    cmp_vld_d  = cmp_vld_q;
    if (cmd_i.load) begin
      scan_idx_d = '0;
      cmp_vld_d  = 1'b0;
    end else if (cmd_i.scan_en && !sts_o.hit) begin
      cmp_vld_d = issue;
      if (issue) scan_idx_d = scan_idx_q + 1'b1;
    end
  end

  always_comb begin
    count_d   = count_q;
    last_d    = last_q;
    code_d    = last_q;
    added_d   = 1'b0;
    dropped_d = 1'b0;
    if (cmd_i.load && start_req_i) begin
      count_d = '0;
      last_d  = '0;
    end else if (cmd_i.commit) begin
      priority if (sts_o.hit) begin
        code_d = 8'(cmp_idx_q) + CodeBase;
        last_d = code_d;
      end else if (append) begin
        code_d  = 8'(count_q) + CodeBase;
        last_d  = code_d;
        count_d = count_q + 1'b1;
        added_d = 1'b1;
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (append) mem[count_q[IdxW-1:0]] <= color_q;
    if (issue)  rdata_q <= mem[scan_idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) color_q <= {red_i, green_i, blue_i};
    if (issue)      cmp_idx_q <= scan_idx_q[IdxW-1:0];
    if (cmd_i.commit) begin
      code_o          <= code_d;
      added_o         <= added_d;
      dropped_o       <= dropped_d;
      palette_count_o <= 8'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      last_q     <= '0;
      scan_idx_q <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      count_q    <= count_d;
      last_q     <= last_d;
      scan_idx_q <= scan_idx_d;
      cmp_vld_q  <= cmp_vld_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/first_seen_palette_builder_unit.sv =====
// Top level of the first-seen palette builder.
//
// pix_i carries one pixel (red, green, blue, start_req) per item; res_o carries
// one result (code, added, dropped, palette_count) per pixel, in order.
// A pixel with start_req set empties the palette and clears the last code
// before it is looked up, so it always lands as entry 0 (code 32).
// The pixel is compared against the stored entries lowest index first, one
// entry per cycle through the single read port of the palette memory.
// pix_i.ready is high only while no search is running; the next pixel is
// taken the cycle after the previous result is committed.
// The result sits in an output register: while res_o is stalled a new pixel
// is still accepted and searched, and its result waits until res_o drains.
// Reset empties the palette, clears the last code and drops any pending
// result; palette contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module first_seen_palette_builder_unit
  import fspb_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fspb_pix_if.sink    pix_i,
  fspb_res_if.source  res_o
);

  fspb_cmd_t cmd;
  fspb_sts_t sts;

  fspb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fspb_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .red_i           (pix_i.red),
    .green_i         (pix_i.green),
    .blue_i          (pix_i.blue),
    .start_req_i     (pix_i.start_req),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .code_o          (res_o.code),
    .added_o         (res_o.added),
    .dropped_o       (res_o.dropped),
    .palette_count_o (res_o.palette_count)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the first-seen palette builder: scoreboard, stream drivers, watchdog.
`timescale 1ns / 1ps

import fspb_pkg::*;

typedef struct packed {
  logic [7:0] code;
  logic       added;
  logic       dropped;
  logic [7:0] count;
} code_rec_t;

class palette_scoreboard;
  int unsigned depth;
  logic [23:0] colors[];
  int unsigned n_entries;
  logic [7:0]  last_code;
  code_rec_t   expected_codes[$];
  int n_pixels, n_checked, n_errors;
  int n_hits, n_added, n_dropped, n_full;

  function new(int unsigned d);
    depth     = d;
    colors    = new[d];
    n_entries = 0;
    last_code = '0;
  endfunction

  // Runs the lookup on an accepted pixel and queues the code it must produce.
  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic first);
    logic [23:0] color;
    int          hit_at;
    code_rec_t   e;
    color  = {r, g, b};
    hit_at = -1;
    e      = '0;
    if (first) begin
      n_entries = 0;
      last_code = '0;
    end
    for (int k = 0; k < n_entries; k++) begin
      if (colors[k] == color) begin
        hit_at = k;
        break;
      end
    end
    if (hit_at >= 0) begin
      e.code    = 8'(hit_at) + CodeBase;
      last_code = e.code;
      n_hits++;
    end else if (n_entries < depth) begin
      colors[n_entries] = color;
      e.code    = 8'(n_entries) + CodeBase;
      last_code = e.code;
      n_entries++;
      e.added   = 1'b1;
      n_added++;
      if (n_entries == depth) n_full++;
    end else begin
      e.code    = last_code;
      e.dropped = 1'b1;
      n_dropped++;
    end
    e.count = 8'(n_entries);
    expected_codes.push_back(e);
    n_pixels++;
  endfunction

  function void check_result(logic [7:0] code, logic added, logic dropped, logic [7:0] count);
    code_rec_t e;
    n_checked++;
    if (expected_codes.size() == 0) begin
      $error("unexpected result: code %0d added %0d dropped %0d count %0d",
             code, added, dropped, count);
      n_errors++;
      return;
    end
    e = expected_codes.pop_front();
    if (code !== e.code) begin
      $error("code: expected %0d, got %0d", e.code, code);
      n_errors++;
    end
    if (added !== e.added) begin
      $error("added: expected %0d, got %0d", e.added, added);
      n_errors++;
    end
    if (dropped !== e.dropped) begin
      $error("dropped: expected %0d, got %0d", e.dropped, dropped);
      n_errors++;
    end
    if (count !== e.count) begin
      $error("palette_count: expected %0d, got %0d", e.count, count);
      n_errors++;
    end
  endfunction

  function int pending();
    return expected_codes.size();
  endfunction
endclass

module testbench;

  localparam int unsigned DEPTH       = PaletteDepthDef;
  localparam int          N_PIXELS    = 650;
  localparam int          HOLD_CYCLES = 2000;
  localparam int          IDLE_LIMIT  = 20000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fspb_pix_if pix ();
  fspb_res_if res ();

  first_seen_palette_builder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res)
  );

  palette_scoreboard sb = new(DEPTH);

  bit no_gaps   = 1'b0;
  int n_images  = 0;
  bit held_once = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    pix.valid     = 1'b0;
    pix.red       = '0;
    pix.green     = '0;
    pix.blue      = '0;
    pix.start_req = 1'b0;
    res.ready     = 1'b0;
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance. valid stays high across back-to-back items.
  task automatic drive_pixel(input logic [23:0] color, input logic first);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid     = 1'b1;
    pix.red       = color[23:16];
    pix.green     = color[15:8];
    pix.blue      = color[7:0];
    pix.start_req = first;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_pixel(color[23:16], color[15:8], color[7:0], first);
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_color();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hffffff;
      default: return 24'($urandom);
    endcase
  endfunction

  // Short image drawn from a handful of colors, so most pixels hit.
  task automatic send_small_image();
    logic [23:0] local_set[$];
    logic [23:0] c;
    int          len;
    len = $urandom_range(3, 40);
    for (int i = 0; i < len; i++) begin
      if (local_set.size() == 0 || $urandom_range(0, 3) == 0) begin
        c = rand_color();
        local_set.push_back(c);
      end else begin
        c = local_set[$urandom_range(0, local_set.size() - 1)];
      end
      // occasional stray start in mid image
      drive_pixel(c, i == 0 || $urandom_range(0, 29) == 0);
    end
    n_images++;
  endtask

  // Mostly fresh colors to push the palette near, to or past its depth.
  task automatic send_fill_image(input int fresh_target);
    logic [23:0] seen[$];
    logic [23:0] c;
    int          fresh;
    bit          first;
    fresh = 0;
    first = 1'b1;
    while (fresh < fresh_target) begin
      if (seen.size() > 0 && $urandom_range(0, 7) == 0) begin
        c = seen[$urandom_range(0, seen.size() - 1)];
      end else begin
        c = 24'($urandom);
        seen.push_back(c);
        fresh++;
      end
      drive_pixel(c, first);
      first = 1'b0;
    end
    n_images++;
  endtask

  // Result side: random stalls, one long hold-off to back up the input.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (!held_once && sb.n_checked >= 150) begin
        res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held_once = 1'b1;
      end else if (stall > 0) begin
        res.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res.ready = 1'b1;
      do @(posedge clk_i); while (!res.valid);
      sb.check_result(res.code, res.added, res.dropped, res.palette_count);
      @(negedge clk_i);
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 idle, sb.pending());
        $display("first_seen_palette_builder_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    bit second_fill;
    second_fill = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: first pixel after reset without start, extremes, restarts
    drive_pixel(24'h000000, 1'b0);
    drive_pixel(24'hffffff, 1'b0);
    drive_pixel(24'h000000, 1'b0);
    drive_pixel(24'hffffff, 1'b0);
    drive_pixel(24'hffffff, 1'b1);
    drive_pixel(24'h000000, 1'b0);
    drive_pixel(24'hff0000, 1'b0);
    drive_pixel(24'h00ff00, 1'b0);
    drive_pixel(24'h0000ff, 1'b0);
    drive_pixel(24'hff0000, 1'b0);
    drive_pixel(24'h000000, 1'b1);
    drive_pixel(24'h000000, 1'b1);
    drive_pixel(24'h800000, 1'b0);
    drive_pixel(24'h008000, 1'b0);
    drive_pixel(24'h000080, 1'b0);
    drive_pixel(24'h010101, 1'b0);
    drive_pixel(24'h7f7f7f, 1'b0);
    drive_pixel(24'h800000, 1'b0);
    drive_pixel(24'h000000, 1'b0);
    n_images += 3;

    // overflow: full palette, then drops mixed with hits
    send_fill_image(DEPTH + $urandom_range(5, 30));
    while (sb.n_pixels < N_PIXELS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!second_fill && sb.n_pixels >= 350) begin
        send_fill_image($urandom_range(DEPTH - 2, DEPTH + 15));
        second_fill = 1'b1;
      end else begin
        send_small_image();
      end
    end
    no_gaps   = 1'b0;
    pix.valid = 1'b0;

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d pixels over %0d images, checked %0d codes", sb.n_pixels, n_images,
             sb.n_checked);
    $display("Lookups: %0d hits, %0d new entries, %0d overflow drops, full palette %0d times",
             sb.n_hits, sb.n_added, sb.n_dropped, sb.n_full);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("first_seen_palette_builder_unit test passed");
    end else begin
      $display("first_seen_palette_builder_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fspb_pkg.sv
src/fspb_if.sv
src/fspb_ctrl.sv
src/fspb_datapath.sv
src/first_seen_palette_builder_unit.sv
bench/testbench.sv
